>>> design/rbd_pkg.sv
// shared constants and types for the ring buffer deque
`timescale 1ns / 1ps
`default_nettype none
package rbd_pkg;

    localparam int DEPTH   = 16;
    localparam int WORD_W  = 32;
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam int OP_W    = 3;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_PEEK_FRONT = 3'd4;
    localparam logic [OP_W-1:0] OP_PEEK_BACK  = 3'd5;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic shift_from_left;   // push at front: whole row moves towards the back
        logic shift_from_right;  // pop at front: whole row moves towards the front
        logic load_back;         // push at back: first empty cell takes the word
        logic drop_back;         // pop at back: last occupied cell empties
    } cell_cmd_t;

endpackage
`default_nettype wire

>>> design/rbd_cell.sv
// one storage cell of the deque chain
`timescale 1ns / 1ps
`default_nettype none
module rbd_cell (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire rbd_pkg::cell_cmd_t        cmd,
    input  wire logic [rbd_pkg::WORD_W-1:0] push_data,
    input  wire logic                      left_valid,
    input  wire logic [rbd_pkg::WORD_W-1:0] left_data,
    input  wire logic                      right_valid,
    input  wire logic [rbd_pkg::WORD_W-1:0] right_data,
    output logic                           valid,
    output logic [rbd_pkg::WORD_W-1:0]      data,
    output logic                           is_back
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [rbd_pkg::WORD_W-1:0] data_reg;
    logic [rbd_pkg::WORD_W-1:0] data_next;

    assign is_back = valid_reg && !right_valid;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (cmd.shift_from_left) begin
            valid_next = left_valid;
            data_next  = left_data;
        end else if (cmd.shift_from_right) begin
            valid_next = right_valid;
            data_next  = right_data;
        end else if (cmd.load_back && !valid_reg && left_valid) begin
            valid_next = 1'b1;
            data_next  = push_data;
        end else if (cmd.drop_back && is_back) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule
`default_nettype wire

>>> design/ring_buffer_deque_unit.sv
// top level of the ring buffer deque: command decode, cell chain and result register
`timescale 1ns / 1ps
`default_nettype none
// Double-ended queue of sixteen signed 32-bit words. Each input word carries an
// operation (push front, push back, pop front, pop back, peek front, peek back)
// and a value; each gives exactly one result word with a success flag, the word
// read (zero when nothing was read) and the fill level after the operation.
// Pushes on a full queue and pops or peeks on an empty one are refused and
// change nothing; codes 6 and 7 are refused too. The words sit in a row of
// cells, front at cell 0: a push or pop at the front shifts the whole row one
// place, while a push or pop at the back touches only the cell at the boundary
// of the occupied run. One word is accepted per cycle whenever the output
// register is empty or being emptied in the same cycle; its result appears in
// that register in the cycle after acceptance. Reset
// clears the occupancy flags, the fill count and the result valid flag but not
// the stored words, so the block is ready straight after reset.
module ring_buffer_deque_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // op [2:0], value_in [34:3], zero [39:35]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata    // ok [0], value_out [32:1], fill_level [37:33], zero [39:38]
);

    localparam int DEPTH   = rbd_pkg::DEPTH;
    localparam int WORD_W  = rbd_pkg::WORD_W;
    localparam int COUNT_W = rbd_pkg::COUNT_W;

    // input word fields
    logic [rbd_pkg::OP_W-1:0] in_op;
    logic [WORD_W-1:0]        in_value;
    logic                     in_fire;

    assign in_op    = s_tdata[rbd_pkg::OP_W-1:0];
    assign in_value = s_tdata[rbd_pkg::OP_W +: WORD_W];
    assign in_fire  = s_tvalid && s_tready;

    // cell chain taps
    logic [DEPTH-1:0]  cell_valid;
    logic [WORD_W-1:0] cell_data [DEPTH];
    logic [DEPTH-1:0]  cell_back;

    rbd_pkg::cell_cmd_t cmd;

    // occupancy is a thermometer code: empty when the first cell is free,
    // full when the last cell is taken
    logic chain_empty;
    logic chain_full;

    assign chain_empty = !cell_valid[0];
    assign chain_full  = cell_valid[DEPTH-1];

    // back word: at most one cell flags itself as the end of the occupied run, none when empty
    logic [WORD_W-1:0] back_data;

    always_comb begin
        back_data = '0;
        for (int i = 0; i < DEPTH; i++) begin
            back_data = back_data | (cell_back[i] ? cell_data[i] : '0);
        end
    end

    // fill level register
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    // decode
    logic              res_ok;
    logic [WORD_W-1:0] res_value;

    always_comb begin
        cmd        = '0;
        res_ok     = 1'b0;
        res_value  = '0;
        count_next = count_reg;
        unique case (in_op)
            rbd_pkg::OP_PUSH_FRONT: begin
                if (!chain_full) begin
                    cmd.shift_from_left = in_fire;
                    res_ok              = 1'b1;
                    count_next          = count_reg + COUNT_W'(1);
                end
            end
            rbd_pkg::OP_PUSH_BACK: begin
                if (!chain_full) begin
                    cmd.load_back = in_fire;
                    res_ok        = 1'b1;
                    count_next    = count_reg + COUNT_W'(1);
                end
            end
            rbd_pkg::OP_POP_FRONT: begin
                if (!chain_empty) begin
                    cmd.shift_from_right = in_fire;
                    res_ok               = 1'b1;
                    res_value            = cell_data[0];
                    count_next           = count_reg - COUNT_W'(1);
                end
            end
            rbd_pkg::OP_POP_BACK: begin
                if (!chain_empty) begin
                    cmd.drop_back = in_fire;
                    res_ok        = 1'b1;
                    res_value     = back_data;
                    count_next    = count_reg - COUNT_W'(1);
                end
            end
            rbd_pkg::OP_PEEK_FRONT: begin
                if (!chain_empty) begin
                    res_ok    = 1'b1;
                    res_value = cell_data[0];
                end
            end
            rbd_pkg::OP_PEEK_BACK: begin
                if (!chain_empty) begin
                    res_ok    = 1'b1;
                    res_value = back_data;
                end
            end
            default: begin
                // unknown code: refused, nothing changes
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (in_fire) begin
            count_reg <= count_next;
        end
    end

    // the chain: cell 0 sees the pushed word as its left neighbour, the last
    // cell sees an always-empty neighbour on its right
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic              left_v;
        logic [WORD_W-1:0] left_d;
        logic              right_v;
        logic [WORD_W-1:0] right_d;

        if (g == 0) begin : g_first
            assign left_v = 1'b1;
            assign left_d = in_value;
        end else begin : g_mid
            assign left_v = cell_valid[g-1];
            assign left_d = cell_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_v = 1'b0;
            assign right_d = '0;
        end else begin : g_inner
            assign right_v = cell_valid[g+1];
            assign right_d = cell_data[g+1];
        end

        rbd_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cmd         (cmd),
            .push_data   (in_value),
            .left_valid  (left_v),
            .left_data   (left_d),
            .right_valid (right_v),
            .right_data  (right_d),
            .valid       (cell_valid[g]),
            .data        (cell_data[g]),
            .is_back     (cell_back[g])
        );
    end

    // result register, parts the input side from the output side
    logic        m_valid_reg;
    logic [39:0] m_data_reg;

    assign s_tready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            m_data_reg <= {2'b00, count_next, res_value, res_ok};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
`default_nettype wire

>>> dv/ring_buffer_deque_unit_test.sv
// self-checking testbench for the ring buffer deque top level
`timescale 1ns / 1ps
module ring_buffer_deque_unit_test;

    localparam int DEPTH   = rbd_pkg::DEPTH;
    localparam int WORD_W  = rbd_pkg::WORD_W;
    localparam int COUNT_W = rbd_pkg::COUNT_W;
    localparam int OP_W    = rbd_pkg::OP_W;

    // codes outside the defined operation set, must be refused
    localparam logic [OP_W-1:0] OP_BAD_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_BAD_7 = 3'd7;

    localparam int PHASES     = 4;
    localparam int RAND_WORDS = 175;   // random words per phase
    localparam int CHUNK      = 35;    // words sharing one push/pop bias

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [WORD_W-1:0] value;
    } deque_cmd_t;

    typedef struct packed {
        logic               ok;
        logic [WORD_W-1:0]  value;
        logic [COUNT_W-1:0] fill;
    } deque_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;     // op [2:0], value_in [34:3], zero [39:35]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;          // ok [0], value_out [32:1], fill_level [37:33], zero [39:38]

    ring_buffer_deque_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    deque_cmd_t    pending_cmds[$];
    deque_result_t expected_results[$];

    int  words_queued   = 0;
    int  words_accepted = 0;
    int  refused_count  = 0;
    int  peak_fill      = 0;
    int  error_count    = 0;
    int  sender_idle_pct    = 0;
    int  receiver_stall_pct = 0;
    logic word_taken = 1'b0;

    // shadow copy of the deque contents
    logic [WORD_W-1:0]  shadow_ring[DEPTH];
    int                 shadow_head  = 0;
    int                 shadow_tail  = 0;
    int                 shadow_count = 0;

    initial begin
        foreach (shadow_ring[i]) shadow_ring[i] = '0;
    end

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int ring_next(int i);
        return (i == DEPTH - 1) ? 0 : i + 1;
    endfunction

    function automatic int ring_prev(int i);
        return (i == 0) ? DEPTH - 1 : i - 1;
    endfunction

    // apply one operation to the shadow deque and give the result it should produce
    task automatic deque_apply(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] word,
                               output deque_result_t res);
        res = '0;
        case (op)
            rbd_pkg::OP_PUSH_FRONT, rbd_pkg::OP_PUSH_BACK: begin
                if (shadow_count < DEPTH) begin
                    if (shadow_count == 0) begin
                        shadow_head = 0;
                        shadow_tail = 0;
                        shadow_ring[0] = word;
                    end else if (op == rbd_pkg::OP_PUSH_FRONT) begin
                        shadow_head = ring_prev(shadow_head);
                        shadow_ring[shadow_head] = word;
                    end else begin
                        shadow_tail = ring_next(shadow_tail);
                        shadow_ring[shadow_tail] = word;
                    end
                    shadow_count++;
                    res.ok = 1'b1;
                end
            end
            rbd_pkg::OP_POP_FRONT, rbd_pkg::OP_PEEK_FRONT: begin
                if (shadow_count != 0) begin
                    res.value = shadow_ring[shadow_head];
                    res.ok = 1'b1;
                    if (op == rbd_pkg::OP_POP_FRONT) begin
                        shadow_count--;
                        if (shadow_count != 0) shadow_head = ring_next(shadow_head);
                    end
                end
            end
            rbd_pkg::OP_POP_BACK, rbd_pkg::OP_PEEK_BACK: begin
                if (shadow_count != 0) begin
                    res.value = shadow_ring[shadow_tail];
                    res.ok = 1'b1;
                    if (op == rbd_pkg::OP_POP_BACK) begin
                        shadow_count--;
                        if (shadow_count != 0) shadow_tail = ring_prev(shadow_tail);
                    end
                end
            end
            default: ;
        endcase
        res.fill = shadow_count[COUNT_W-1:0];
    endtask

    function automatic void check_field(string name, logic [WORD_W-1:0] want,
                                        logic [WORD_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endfunction

    task automatic queue_cmd(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] value);
        deque_cmd_t c;
        c.op = op;
        c.value = value;
        pending_cmds.push_back(c);
        words_queued++;
    endtask

    // extremes turn up often, the rest is uniform
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_op(int push_pct);
        int r;
        r = $urandom_range(99);
        if (r < 3) return $urandom_range(1) ? OP_BAD_7 : OP_BAD_6;
        if (r < 3 + push_pct) begin
            return $urandom_range(1) ? rbd_pkg::OP_PUSH_BACK : rbd_pkg::OP_PUSH_FRONT;
        end
        case ($urandom_range(5))
            0, 1:    return rbd_pkg::OP_POP_FRONT;
            2, 3:    return rbd_pkg::OP_POP_BACK;
            4:       return rbd_pkg::OP_PEEK_FRONT;
            default: return rbd_pkg::OP_PEEK_BACK;
        endcase
    endfunction

    // driver: offers the next pending word at the falling edge, holds it until taken
    always @(negedge aclk) begin : drive_proc
        logic       offer;
        deque_cmd_t nxt;
        if (aresetn && !(s_tvalid && !word_taken)) begin
            offer = 1'b0;
            nxt = '0;
            if (pending_cmds.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                nxt = pending_cmds.pop_front();
                offer = 1'b1;
            end
            s_tvalid <= offer;
            if (offer) s_tdata <= {5'b0, nxt.value, nxt.op};
        end
    end

    // receiver back-pressure
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // monitor: checks results against the oldest expectation, predicts on acceptance
    always @(posedge aclk) begin : monitor_proc
        deque_result_t want;
        deque_result_t got;
        if (!aresetn) begin
            word_taken <= 1'b0;
        end else begin
            word_taken <= s_tvalid && s_tready;
            if (m_tvalid && m_tready) begin
                got.ok    = m_tdata[0];
                got.value = m_tdata[32:1];
                got.fill  = m_tdata[37:33];
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("ok", WORD_W'(want.ok), WORD_W'(got.ok));
                    check_field("value_out", want.value, got.value);
                    check_field("fill_level", WORD_W'(want.fill), WORD_W'(got.fill));
                end
            end
            if (s_tvalid && s_tready) begin
                deque_apply(s_tdata[2:0], s_tdata[34:3], want);
                expected_results.push_back(want);
                words_accepted++;
                if (!want.ok) refused_count++;
                if (int'(want.fill) > peak_fill) peak_fill = int'(want.fill);
            end
        end
    end

    // stimulus and phase sequencing
    initial begin : stimulus_proc
        int push_pct;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1:       begin sender_idle_pct = 52; receiver_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  receiver_stall_pct = 52; end
                default: begin sender_idle_pct = 16; receiver_stall_pct = 16; end
            endcase

            if (phase == 0) begin
                // empty deque: every read is refused, unknown codes too
                queue_cmd(rbd_pkg::OP_POP_FRONT, 32'hffff_ffff);
                queue_cmd(rbd_pkg::OP_POP_BACK, 32'h8000_0000);
                queue_cmd(rbd_pkg::OP_PEEK_FRONT, 32'h7fff_ffff);
                queue_cmd(rbd_pkg::OP_PEEK_BACK, 32'h0000_0000);
                queue_cmd(OP_BAD_6, 32'hffff_ffff);
                queue_cmd(OP_BAD_7, 32'h0000_0000);
                // fill to capacity from both ends with the extreme words first
                for (int k = 0; k < DEPTH; k++) begin
                    case (k)
                        0:       queue_cmd(rbd_pkg::OP_PUSH_FRONT, 32'h8000_0000);
                        1:       queue_cmd(rbd_pkg::OP_PUSH_BACK, 32'h7fff_ffff);
                        2:       queue_cmd(rbd_pkg::OP_PUSH_FRONT, 32'hffff_ffff);
                        3:       queue_cmd(rbd_pkg::OP_PUSH_BACK, 32'h0000_0000);
                        default: queue_cmd(k[0] ? rbd_pkg::OP_PUSH_BACK : rbd_pkg::OP_PUSH_FRONT,
                                           $urandom);
                    endcase
                end
                // full deque: both pushes refused, peeks still work
                queue_cmd(rbd_pkg::OP_PUSH_FRONT, 32'h1234_5678);
                queue_cmd(rbd_pkg::OP_PUSH_BACK, 32'h8765_4321);
                queue_cmd(rbd_pkg::OP_PEEK_FRONT, 32'h0);
                queue_cmd(rbd_pkg::OP_PEEK_BACK, 32'h0);
                queue_cmd(OP_BAD_7, 32'hffff_ffff);
            end

            // random walks: each chunk leans towards filling, draining or neither
            for (int n = 0; n < RAND_WORDS; n++) begin
                if (n % CHUNK == 0) begin
                    case ($urandom_range(2))
                        0:       push_pct = 70;
                        1:       push_pct = 22;
                        default: push_pct = 45;
                    endcase
                end
                queue_cmd(pick_op(push_pct), pick_word());
            end

            // sender stays quiet until every outstanding result is back
            do @(negedge aclk);
            while (words_accepted != words_queued || expected_results.size() != 0);
        end

        // let any stray result show up
        receiver_stall_pct = 0;
        repeat (8) @(negedge aclk);

        $display("run covered %0d words in %0d handshake phases, %0d of them refused",
                 words_accepted, PHASES, refused_count);
        $display("fill level peaked at %0d of %0d, pointers wrapped in both directions",
                 peak_fill, DEPTH);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("timeout with %0d words pending and %0d results outstanding",
                 pending_cmds.size(), expected_results.size());
        $display("FAILURE");
        $finish;
    end

endmodule

>>> ring_buffer_deque_unit.f
design/rbd_pkg.sv
design/rbd_cell.sv
design/ring_buffer_deque_unit.sv
dv/ring_buffer_deque_unit_test.sv
